[sv/bezier_keyframe_curve_player_top_assert.svh]
// Assertion macros used by the checker file of the curve player.
`ifndef BEZIER_KEYFRAME_CURVE_PLAYER_TOP_ASSERT_SVH
`define BEZIER_KEYFRAME_CURVE_PLAYER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BKCP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("curve player check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BKCP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("curve player check failed");

`endif

[sv/bkcp_pkg.sv]
// Shared constants, types and helper functions of the curve player.
package bkcp_pkg;

	localparam int MAX_KEYS         = 64;
	localparam int MAX_BISECT_STEPS = 24;
	localparam int AW               = $clog2(MAX_KEYS);
	localparam int KW               = $clog2(MAX_KEYS + 1);
	localparam int IW               = $clog2(MAX_BISECT_STEPS + 1);
	localparam int KEY_W            = 192;
	localparam int PAW              = 5;

	localparam logic [16:0] T_ONE  = 17'd65536;
	localparam logic [16:0] T_HALF = 17'd32768;

	localparam logic [2:0] K_APPEND = 3'd0;
	localparam logic [2:0] K_TICK   = 3'd1;
	localparam logic [2:0] K_SET    = 3'd2;
	localparam logic [2:0] K_START  = 3'd3;
	localparam logic [2:0] K_STOP   = 3'd4;
	localparam logic [2:0] K_CLEAR  = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OOR  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_IGN  = 2'd3;

	localparam logic [2:0] R_LOOP  = 3'd0;
	localparam logic [2:0] R_START = 3'd1;
	localparam logic [2:0] R_END   = 3'd2;
	localparam logic [2:0] R_FPS   = 3'd3;
	localparam logic [2:0] R_TOL   = 3'd4;

	localparam logic [7:0]  FPS_RST = 8'd24;
	localparam logic [15:0] TOL_RST = 16'd655;

	// de Casteljau steps of one curve evaluation
	localparam logic [2:0] PH_A = 3'd0;
	localparam logic [2:0] PH_B = 3'd1;
	localparam logic [2:0] PH_C = 3'd2;
	localparam logic [2:0] PH_D = 3'd3;
	localparam logic [2:0] PH_E = 3'd4;
	localparam logic [2:0] PH_F = 3'd5;

	typedef struct packed {
		logic        loop_en;
		logic [15:0] start_frame;
		logic [15:0] end_frame;
		logic [7:0]  fps;
		logic [15:0] tol;
	} cfg_t;

	typedef struct packed {
		logic       cap_in;
		logic       do_append;
		logic       do_clear;
		logic       do_start;
		logic       do_stop;
		logic       rd_k0;
		logic       rd_k1;
		logic       rd_srch;
		logic       cap_k0;
		logic       cap_k1;
		logic       lerp_en;
		logic [2:0] ph;
		logic       use_y;
		logic       bis_upd;
		logic       t_zero;
		logic       tick_fin;
		logic       set_begin;
		logic       srch_next;
		logic       srch_fin;
		logic       st_wr;
		logic [1:0] st_code;
	} cmd_t;

	typedef struct packed {
		logic tick_ign;
		logic set_oor;
		logic full;
		logic frame_pos;
		logic in_tol;
		logic srch_end;
		logic srch_hit;
	} sts_t;

	// Limits a key index to the highest usable segment start for the current key count.
	function automatic logic [KW-1:0] clamp_key(input logic [KW-1:0] k,
		input logic [KW-1:0] kc);
		logic [KW-1:0] top;
		top = (kc >= KW'(2)) ? kc - KW'(2) : '0;
		return (k > top) ? top : k;
	endfunction

endpackage

[sv/bkcp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bkcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/bkcp_dp.sv]
// Datapath: key table, playback state, shared lerp unit and bisection registers.
module bkcp_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bkcp_pkg::cmd_t            cmd,
	input  bkcp_pkg::cfg_t            cfg,
	output bkcp_pkg::sts_t            sts,
	input  logic signed [31:0]        center_x,
	input  logic signed [31:0]        center_y,
	input  logic signed [31:0]        left_x,
	input  logic signed [31:0]        left_y,
	input  logic signed [31:0]        right_x,
	input  logic signed [31:0]        right_y,
	input  logic [31:0]               elapsed,
	input  logic signed [31:0]        frame_value,
	output logic signed [31:0]        curve_value,
	output logic signed [31:0]        frame_now,
	output logic [6:0]                key_now,
	output logic                      playing,
	output logic [1:0]                status
);

	localparam int AW = bkcp_pkg::AW;
	localparam int KW = bkcp_pkg::KW;

	// captured item fields
	logic signed [31:0] cx_q, cy_q, lx_q, ly_q, rx_q, ry_q, frame_q;
	logic [31:0]        elapsed_q;

	// playback state
	logic [KW-1:0]      kc_q, ki_q, i_q;
	logic signed [31:0] pf_q, lv_q;
	logic               run_q;
	logic [1:0]         st_q;

	// segment control points
	logic signed [31:0] k0cx_q, k0cy_q, k0rx_q, k0ry_q;
	logic signed [31:0] k1cx_q, k1cy_q, k1lx_q, k1ly_q;
	logic [39:0]        mul_q;

	// bisection and de Casteljau registers
	logic [16:0]        t_q, lo_q, hi_q;
	logic signed [31:0] ra_q, rb_q, rc_q, res_q;

	logic [AW-1:0]       raddr;
	logic [KW-1:0]       seg, seg1;
	logic [KW*0+191:0]   rdata;
	logic                we;

	logic signed [31:0] p0, p1, p2, p3, la, lb, lres;
	logic signed [32:0] ldiff;
	logic signed [50:0] lprod;
	logic signed [32:0] xd, xabs;
	logic               gt;
	logic [16:0]        lo_n, hi_n;
	logic [17:0]        tsum;
	logic signed [41:0] nf;
	logic signed [31:0] nfs;
	logic signed [32:0] f33;

	assign seg  = bkcp_pkg::clamp_key(ki_q, kc_q);
	assign seg1 = seg + KW'(1);
	assign we   = cmd.do_append && (kc_q < KW'(bkcp_pkg::MAX_KEYS));

	always_comb begin
		if (cmd.rd_k0) begin
			raddr = seg[AW-1:0];
		end else if (cmd.rd_k1) begin
			raddr = seg1[AW-1:0];
		end else if (cmd.rd_srch) begin
			raddr = i_q[AW-1:0];
		end else begin
			raddr = '0;
		end
	end

	bkcp_ram #(
		.WIDTH(bkcp_pkg::KEY_W),
		.DEPTH(bkcp_pkg::MAX_KEYS)
	) u_keys (
		.clk  (clk),
		.we   (we),
		.waddr(kc_q[AW-1:0]),
		.wdata({ry_q, rx_q, ly_q, lx_q, cy_q, cx_q}),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Control points of the x or the y curve.
	always_comb begin
		if (cmd.use_y) begin
			p0 = k0cy_q; p1 = k0ry_q; p2 = k1ly_q; p3 = k1cy_q;
		end else begin
			p0 = k0cx_q; p1 = k0rx_q; p2 = k1lx_q; p3 = k1cx_q;
		end
		case (cmd.ph)
			bkcp_pkg::PH_A: begin la = p0;   lb = p1;   end
			bkcp_pkg::PH_B: begin la = p1;   lb = p2;   end
			bkcp_pkg::PH_C: begin la = p2;   lb = p3;   end
			bkcp_pkg::PH_D: begin la = ra_q; lb = rb_q; end
			bkcp_pkg::PH_E: begin la = rb_q; lb = rc_q; end
			bkcp_pkg::PH_F: begin la = ra_q; lb = rb_q; end
			default:        begin la = p0;   lb = p1;   end
		endcase
	end

	// a + floor((b - a) * t / 65536); the result lies between a and b.
	assign ldiff = $signed({lb[31], lb}) - $signed({la[31], la});
	assign lprod = ldiff * $signed({1'b0, t_q});
	assign lres  = la + lprod[47:16];

	assign xd   = $signed({pf_q[31], pf_q}) - $signed({res_q[31], res_q});
	assign xabs = (xd < 0) ? -xd : xd;
	assign gt   = pf_q > res_q;
	assign lo_n = gt ? t_q : lo_q;
	assign hi_n = gt ? hi_q : t_q;
	assign tsum = {1'b0, lo_n} + {1'b0, hi_n};

	assign nf  = $signed({{10{pf_q[31]}}, pf_q}) + $signed({2'b00, mul_q});
	assign nfs = (nf > 42'sh7FFFFFFF) ? 32'sh7FFFFFFF : nf[31:0];
	assign f33 = $signed({frame_q[31], frame_q});

	always_comb begin
		sts.tick_ign  = !run_q || (cfg.end_frame == 16'd0) || (kc_q < KW'(2));
		sts.set_oor   = (f33 < $signed({1'b0, cfg.start_frame, 16'h0}))
			|| (f33 > $signed({1'b0, cfg.end_frame, 16'h0}));
		sts.full      = (kc_q == KW'(bkcp_pkg::MAX_KEYS));
		sts.frame_pos = pf_q > 0;
		sts.in_tol    = xabs <= $signed({17'b0, cfg.tol});
		sts.srch_end  = (i_q >= kc_q);
		sts.srch_hit  = frame_q <= $signed(rdata[31:0]);
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			cx_q <= center_x; cy_q <= center_y;
			lx_q <= left_x;   ly_q <= left_y;
			rx_q <= right_x;  ry_q <= right_y;
			elapsed_q <= elapsed;
			frame_q   <= frame_value;
		end
		if (cmd.cap_k0) begin
			k0cx_q <= rdata[31:0];
			k0cy_q <= rdata[63:32];
			k0rx_q <= rdata[159:128];
			k0ry_q <= rdata[191:160];
			mul_q  <= {32'b0, cfg.fps} * {8'b0, elapsed_q};
		end
		if (cmd.cap_k1) begin
			k1cx_q <= rdata[31:0];
			k1cy_q <= rdata[63:32];
			k1lx_q <= rdata[95:64];
			k1ly_q <= rdata[127:96];
		end
		if (cmd.lerp_en) begin
			case (cmd.ph)
				bkcp_pkg::PH_A: ra_q <= lres;
				bkcp_pkg::PH_B: rb_q <= lres;
				bkcp_pkg::PH_C: rc_q <= lres;
				bkcp_pkg::PH_D: ra_q <= lres;
				bkcp_pkg::PH_E: rb_q <= lres;
				bkcp_pkg::PH_F: res_q <= lres;
				default:        ra_q <= lres;
			endcase
		end
		if (cmd.cap_k1) begin
			lo_q <= '0;
			hi_q <= bkcp_pkg::T_ONE;
			t_q  <= bkcp_pkg::T_HALF;
		end else if (cmd.bis_upd) begin
			lo_q <= lo_n;
			hi_q <= hi_n;
			t_q  <= tsum[17:1];
		end else if (cmd.t_zero) begin
			t_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kc_q  <= '0;
			ki_q  <= '0;
			i_q   <= '0;
			pf_q  <= '0;
			lv_q  <= '0;
			run_q <= 1'b0;
			st_q  <= bkcp_pkg::ST_OK;
		end else begin
			if (we) begin
				kc_q <= kc_q + KW'(1);
			end
			if (cmd.do_clear) begin
				kc_q <= '0;
				ki_q <= '0;
			end
			if (cmd.do_start) begin
				run_q <= 1'b1;
			end
			if (cmd.do_stop) begin
				run_q <= 1'b0;
			end
			if (cmd.tick_fin) begin
				lv_q <= res_q;
				if ($signed({nfs[31], nfs}) >= $signed({1'b0, cfg.end_frame, 16'h0})) begin
					if (cfg.loop_en) begin
						pf_q <= '0;
						ki_q <= '0;
					end else begin
						run_q <= 1'b0;
						pf_q  <= nfs;
						ki_q  <= (nfs > k1cx_q) ? bkcp_pkg::clamp_key(seg1, kc_q) : seg;
					end
				end else begin
					pf_q <= nfs;
					ki_q <= (nfs > k1cx_q) ? bkcp_pkg::clamp_key(seg1, kc_q) : seg;
				end
			end
			if (cmd.set_begin) begin
				pf_q <= frame_q;
				i_q  <= '0;
			end
			if (cmd.srch_next) begin
				i_q <= i_q + KW'(1);
			end
			if (cmd.srch_fin) begin
				ki_q <= bkcp_pkg::clamp_key(i_q, kc_q);
			end
			if (cmd.st_wr) begin
				st_q <= cmd.st_code;
			end
		end
	end

	assign curve_value = lv_q;
	assign frame_now   = pf_q;
	assign key_now     = 7'(ki_q);
	assign playing     = run_q;
	assign status      = st_q;

endmodule

[sv/bkcp_ctrl.sv]
// Controller: sequences item kinds, key reads, bisection and key search.
module bkcp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [2:0]     kind,
	input  bkcp_pkg::sts_t sts,
	output bkcp_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done
);

	localparam int IW = bkcp_pkg::IW;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_EXEC = 10'b0000000010,
		S_RD1  = 10'b0000000100,
		S_CAP  = 10'b0000001000,
		S_XBZ  = 10'b0000010000,
		S_CHK  = 10'b0000100000,
		S_YBZ  = 10'b0001000000,
		S_FIN  = 10'b0010000000,
		S_SRD  = 10'b0100000000,
		S_SCMP = 10'b1000000000
	} state_t;

	state_t        state_q, state_d;
	logic [2:0]    kind_q, ph_q, ph_d;
	logic [IW-1:0] iter_q, iter_d;
	logic          done_q, done_d;

	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		iter_d  = iter_q;
		done_d  = 1'b0;
		cmd     = '0;
		cmd.ph  = ph_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.cap_in = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d     = S_IDLE;
				done_d      = 1'b1;
				cmd.st_wr   = 1'b1;
				cmd.st_code = bkcp_pkg::ST_OK;
				case (kind_q)
					bkcp_pkg::K_APPEND: begin
						cmd.do_append = 1'b1;
						if (sts.full) begin
							cmd.st_code = bkcp_pkg::ST_FULL;
						end
					end
					bkcp_pkg::K_TICK: begin
						if (sts.tick_ign) begin
							cmd.st_code = bkcp_pkg::ST_IGN;
						end else begin
							cmd.st_wr = 1'b0;
							done_d    = 1'b0;
							cmd.rd_k0 = 1'b1;
							state_d   = S_RD1;
						end
					end
					bkcp_pkg::K_SET: begin
						if (sts.set_oor) begin
							cmd.st_code = bkcp_pkg::ST_OOR;
						end else begin
							cmd.st_wr     = 1'b0;
							done_d        = 1'b0;
							cmd.set_begin = 1'b1;
							state_d       = S_SRD;
						end
					end
					bkcp_pkg::K_START: cmd.do_start = 1'b1;
					bkcp_pkg::K_STOP:  cmd.do_stop  = 1'b1;
					bkcp_pkg::K_CLEAR: cmd.do_clear = 1'b1;
					default:           cmd.st_code  = bkcp_pkg::ST_OK;
				endcase
			end
			S_RD1: begin
				cmd.rd_k1  = 1'b1;
				cmd.cap_k0 = 1'b1;
				state_d    = S_CAP;
			end
			S_CAP: begin
				cmd.cap_k1 = 1'b1;
				iter_d     = '0;
				ph_d       = bkcp_pkg::PH_A;
				state_d    = S_XBZ;
			end
			S_XBZ: begin
				cmd.lerp_en = 1'b1;
				if (ph_q == bkcp_pkg::PH_F) begin
					ph_d    = bkcp_pkg::PH_A;
					state_d = S_CHK;
				end else begin
					ph_d = ph_q + 3'd1;
				end
			end
			S_CHK: begin
				if (!sts.frame_pos) begin
					cmd.t_zero = 1'b1;
					state_d    = S_YBZ;
				end else if ((iter_q == IW'(bkcp_pkg::MAX_BISECT_STEPS)) || sts.in_tol) begin
					state_d = S_YBZ;
				end else begin
					cmd.bis_upd = 1'b1;
					iter_d      = iter_q + IW'(1);
					state_d     = S_XBZ;
				end
			end
			S_YBZ: begin
				cmd.lerp_en = 1'b1;
				cmd.use_y   = 1'b1;
				if (ph_q == bkcp_pkg::PH_F) begin
					ph_d    = bkcp_pkg::PH_A;
					state_d = S_FIN;
				end else begin
					ph_d = ph_q + 3'd1;
				end
			end
			S_FIN: begin
				cmd.tick_fin = 1'b1;
				cmd.st_wr    = 1'b1;
				cmd.st_code  = bkcp_pkg::ST_OK;
				done_d       = 1'b1;
				state_d      = S_IDLE;
			end
			S_SRD: begin
				if (sts.srch_end) begin
					cmd.srch_fin = 1'b1;
					cmd.st_wr    = 1'b1;
					cmd.st_code  = bkcp_pkg::ST_OK;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.rd_srch = 1'b1;
					state_d     = S_SCMP;
				end
			end
			S_SCMP: begin
				if (sts.srch_hit) begin
					cmd.srch_fin = 1'b1;
					cmd.st_wr    = 1'b1;
					cmd.st_code  = bkcp_pkg::ST_OK;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.srch_next = 1'b1;
					state_d       = S_SRD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= bkcp_pkg::PH_A;
			iter_q  <= '0;
			done_q  <= 1'b0;
			kind_q  <= bkcp_pkg::K_APPEND;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			iter_q  <= iter_d;
			done_q  <= done_d;
			if (cmd.cap_in) begin
				kind_q <= kind;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

[sv/bezier_keyframe_curve_player_top.sv]
// Append, start, stop, clear, ignored tick and rejected set-frame finish in the execute state.
// A tick reads both segment keys, then evaluates x once plus once per bisection refinement
// (at most 24), then y, on the shared lerp unit, which does one de Casteljau step a cycle.
// A set-frame reads keys in order until a key's x is at or above the frame or the keys run out.
// One item at a time: the next is taken at the edge that ends done; the receiver cannot stall.
// Reset (arst_n low) clears playback state and registers; the key table has no reset.
module bezier_keyframe_curve_player_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	output logic                          done,
	input  logic [2:0]                    kind,
	input  logic signed [31:0]            center_x,
	input  logic signed [31:0]            center_y,
	input  logic signed [31:0]            left_x,
	input  logic signed [31:0]            left_y,
	input  logic signed [31:0]            right_x,
	input  logic signed [31:0]            right_y,
	input  logic [31:0]                   elapsed,
	input  logic signed [31:0]            frame_value,
	output logic signed [31:0]            curve_value,
	output logic signed [31:0]            frame_now,
	output logic [6:0]                    key_now,
	output logic                          playing,
	output logic [1:0]                    status,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bkcp_pkg::PAW-1:0]      paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// Configuration registers. The user must see that they are written only while no item
	// is in flight, so the datapath can read them directly; the block does not enforce it.
	bkcp_pkg::cfg_t cfg_q;
	bkcp_pkg::cmd_t cmd;
	bkcp_pkg::sts_t sts;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.loop_en     <= 1'b0;
			cfg_q.start_frame <= '0;
			cfg_q.end_frame   <= '0;
			cfg_q.fps         <= bkcp_pkg::FPS_RST;
			cfg_q.tol         <= bkcp_pkg::TOL_RST;
		end else if (wr_en) begin
			case (paddr[bkcp_pkg::PAW-1:2])
				bkcp_pkg::R_LOOP:  cfg_q.loop_en     <= pwdata[0];
				bkcp_pkg::R_START: cfg_q.start_frame <= pwdata[15:0];
				bkcp_pkg::R_END:   cfg_q.end_frame   <= pwdata[15:0];
				bkcp_pkg::R_FPS:   cfg_q.fps         <= pwdata[7:0];
				bkcp_pkg::R_TOL:   cfg_q.tol         <= pwdata[15:0];
				default:           cfg_q             <= cfg_q;
			endcase
		end
	end

	// Register read-back, zero extended to the bus width.
	always_comb begin
		case (paddr[bkcp_pkg::PAW-1:2])
			bkcp_pkg::R_LOOP:  prdata = {31'b0, cfg_q.loop_en};
			bkcp_pkg::R_START: prdata = {16'b0, cfg_q.start_frame};
			bkcp_pkg::R_END:   prdata = {16'b0, cfg_q.end_frame};
			bkcp_pkg::R_FPS:   prdata = {24'b0, cfg_q.fps};
			bkcp_pkg::R_TOL:   prdata = {16'b0, cfg_q.tol};
			default:           prdata = '0;
		endcase
	end

	// The controller decodes each item and steps the datapath through table
	// reads, the curve evaluations of the bisection and the key search.
	bkcp_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.kind  (kind),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// The datapath holds the key table, the playback state and the result
	// fields, which stay stable while done is high.
	bkcp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.sts        (sts),
		.center_x   (center_x),
		.center_y   (center_y),
		.left_x     (left_x),
		.left_y     (left_y),
		.right_x    (right_x),
		.right_y    (right_y),
		.elapsed    (elapsed),
		.frame_value(frame_value),
		.curve_value(curve_value),
		.frame_now  (frame_now),
		.key_now    (key_now),
		.playing    (playing),
		.status     (status)
	);

endmodule

[sv/bkcp_checker.sv]
// Port-level checker of the curve player and its bind to the top level.
`include "bezier_keyframe_curve_player_top_assert.svh"

module bkcp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] frame_now,
	input logic [1:0]         status
);

	logic rejected;

	assign rejected = done && ((status == bkcp_pkg::ST_OOR) || (status == bkcp_pkg::ST_IGN));

	`BKCP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`BKCP_ASSERT_NOW(a_done_after_work, done, $past(busy))
	`BKCP_ASSERT_NEXT(a_done_single, done, !done)
	`BKCP_ASSERT_NOW(a_reject_keeps_frame, rejected, $stable(frame_now))

endmodule

bind bezier_keyframe_curve_player_top bkcp_checker u_bkcp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.frame_now(frame_now),
	.status   (status)
);

[tb/sv/tb_bezier_keyframe_curve_player_top.sv]
// Self-checking testbench of the Bezier keyframe curve player.
`timescale 1ns / 1ps

module tb_bezier_keyframe_curve_player_top;

	// Table depth and refinement cap of the player under test.
	localparam int NKEYS = bkcp_pkg::MAX_KEYS;
	localparam int NBIS  = bkcp_pkg::MAX_BISECT_STEPS;
	localparam int WATCHDOG_LIMIT = 20000;

	// One result of the player, in the order of its ports.
	typedef struct {
		logic signed [31:0] curve;
		logic signed [31:0] frame;
		logic [6:0]         key;
		logic               play;
		logic [1:0]         stat;
	} result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	logic [2:0] kind;
	logic signed [31:0] center_x, center_y, left_x, left_y, right_x, right_y;
	logic [31:0] elapsed;
	logic signed [31:0] frame_value;
	logic signed [31:0] curve_value, frame_now;
	logic [6:0] key_now;
	logic playing;
	logic [1:0] status;
	logic psel, penable, pwrite;
	logic [bkcp_pkg::PAW-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	// Shadow copy of the player's state and registers.
	logic signed [31:0] keys_cx[NKEYS], keys_cy[NKEYS], keys_lx[NKEYS];
	logic signed [31:0] keys_ly[NKEYS], keys_rx[NKEYS], keys_ry[NKEYS];
	int unsigned n_keys;
	logic signed [31:0] cur_frame;
	int unsigned cur_key;
	bit is_running;
	logic signed [31:0] held_value;
	bit reg_loop;
	logic [15:0] reg_start, reg_end, reg_tol;
	logic [7:0] reg_fps;

	result_t pending_results[$];
	int errors;
	int idle_cycles;
	bit calm_sender;

	bezier_keyframe_curve_player_top uut (.*);

	always #10 clk = ~clk;

	// Lerp from a to b: a plus the floor of (b - a) * t scaled down by 2^16, as an arithmetic shift.
	function automatic longint lerp_q16(longint a, longint b, longint t);
		return a + ((b - a) * t >>> 16);
	endfunction

	// Cubic curve point by de Casteljau subdivision at t in Q0.16.
	function automatic longint curve_point(longint t, longint p0, longint p1,
		longint p2, longint p3);
		longint a, b, c, d, e;
		a = lerp_q16(p0, p1, t);
		b = lerp_q16(p1, p2, t);
		c = lerp_q16(p2, p3, t);
		d = lerp_q16(a, b, t);
		e = lerp_q16(b, c, t);
		return lerp_q16(d, e, t);
	endfunction

	function automatic int unsigned last_segment(int unsigned k);
		int unsigned top;
		top = (n_keys >= 2) ? n_keys - 2 : 0;
		return (k > top) ? top : k;
	endfunction

	// Finds t where the segment's x meets the frame, then returns y there.
	function automatic longint segment_value(int unsigned s, longint target);
		longint lo, hi, t, x, gap;
		lo = 0;
		hi = 65536;
		t = 32768;
		x = curve_point(t, keys_cx[s], keys_rx[s], keys_lx[s+1], keys_cx[s+1]);
		if (target > 0) begin
			for (int n = 0; n < NBIS; n++) begin
				gap = target - x;
				if (gap < 0) gap = -gap;
				if (gap <= longint'(reg_tol)) break;
				if (target > x) lo = t;
				else hi = t;
				t = (lo + hi) / 2;
				x = curve_point(t, keys_cx[s], keys_rx[s], keys_lx[s+1], keys_cx[s+1]);
			end
		end else begin
			t = 0;
		end
		return curve_point(t, keys_cy[s], keys_ry[s], keys_ly[s+1], keys_cy[s+1]);
	endfunction

	// Applies one item to the shadow state and returns the result it gives.
	function automatic result_t player_step(logic [2:0] k, logic signed [31:0] cx,
		logic signed [31:0] cy, logic signed [31:0] lx, logic signed [31:0] ly,
		logic signed [31:0] rx, logic signed [31:0] ry, logic [31:0] el,
		logic signed [31:0] fv);
		result_t r;
		logic [1:0] st;
		int unsigned s, found;
		longint y, nf;
		st = bkcp_pkg::ST_OK;
		case (k)
			bkcp_pkg::K_APPEND: begin
				if (n_keys >= NKEYS) begin
					st = bkcp_pkg::ST_FULL;
				end else begin
					keys_cx[n_keys] = cx;
					keys_cy[n_keys] = cy;
					keys_lx[n_keys] = lx;
					keys_ly[n_keys] = ly;
					keys_rx[n_keys] = rx;
					keys_ry[n_keys] = ry;
					n_keys++;
				end
			end
			bkcp_pkg::K_TICK: begin
				if (!is_running || reg_end == 0 || n_keys < 2) begin
					st = bkcp_pkg::ST_IGN;
				end else begin
					s = last_segment(cur_key);
					y = segment_value(s, longint'(cur_frame));
					nf = longint'(cur_frame) + longint'(reg_fps) * longint'(el);
					if (nf > 64'sh7FFFFFFF) nf = 64'sh7FFFFFFF;
					cur_frame = nf[31:0];
					cur_key = s;
					if (nf > longint'(keys_cx[s+1])) cur_key = last_segment(s + 1);
					if (nf >= longint'(reg_end) * 65536) begin
						if (reg_loop) begin
							cur_frame = 0;
							cur_key = 0;
						end else begin
							is_running = 0;
						end
					end
					held_value = y[31:0];
				end
			end
			bkcp_pkg::K_SET: begin
				if (longint'(fv) < longint'(reg_start) * 65536 ||
					longint'(fv) > longint'(reg_end) * 65536) begin
					st = bkcp_pkg::ST_OOR;
				end else begin
					cur_frame = fv;
					found = 0;
					for (int i = 0; i < n_keys; i++) begin
						if (fv <= keys_cx[i]) break;
						found++;
					end
					cur_key = last_segment(found);
				end
			end
			bkcp_pkg::K_START: is_running = 1;
			bkcp_pkg::K_STOP: is_running = 0;
			bkcp_pkg::K_CLEAR: begin
				n_keys = 0;
				cur_key = 0;
			end
			default: ;
		endcase
		r.curve = held_value;
		r.frame = cur_frame;
		r.key = cur_key[6:0];
		r.play = is_running;
		r.stat = st;
		return r;
	endfunction

	// Sends one item, predicts its result, and waits until the player takes it.
	task automatic send_item(logic [2:0] k, logic signed [31:0] cx = 0,
		logic signed [31:0] cy = 0, logic signed [31:0] lx = 0,
		logic signed [31:0] ly = 0, logic signed [31:0] rx = 0,
		logic signed [31:0] ry = 0, logic [31:0] el = 0, logic signed [31:0] fv = 0);
		result_t pred;
		while (!calm_sender && $urandom_range(99) < 13) @(posedge clk);
		start <= 1;
		kind <= k;
		center_x <= cx;
		center_y <= cy;
		left_x <= lx;
		left_y <= ly;
		right_x <= rx;
		right_y <= ry;
		elapsed <= el;
		frame_value <= fv;
		do @(posedge clk); while (busy);
		pred = player_step(k, cx, cy, lx, ly, rx, ry, el, fv);
		pending_results = {pending_results, pred};
		start <= 0;
		// The player raises busy after this edge; let it show before the next item.
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write over the APB port; only called with no item in flight.
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= bkcp_pkg::PAW'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			bkcp_pkg::R_LOOP: reg_loop = value[0];
			bkcp_pkg::R_START: reg_start = value[15:0];
			bkcp_pkg::R_END: reg_end = value[15:0];
			bkcp_pkg::R_FPS: reg_fps = value[7:0];
			bkcp_pkg::R_TOL: reg_tol = value[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_registers(bit lp, logic [15:0] sf, logic [15:0] ef,
		logic [7:0] fps, logic [15:0] tol);
		drain();
		write_reg(bkcp_pkg::R_LOOP, 32'(lp));
		write_reg(bkcp_pkg::R_START, 32'(sf));
		write_reg(bkcp_pkg::R_END, 32'(ef));
		write_reg(bkcp_pkg::R_FPS, 32'(fps));
		write_reg(bkcp_pkg::R_TOL, 32'(tol));
	endtask

	// Appends a key whose x lies near the given frame, handles close by.
	task automatic append_near(int frame_whole);
		int base;
		base = frame_whole * 65536;
		send_item(bkcp_pkg::K_APPEND, base, $urandom, base - $urandom_range(200000),
			$urandom, base + $urandom_range(200000), $urandom);
	endtask

	// Every field at its extremes, and the table-full, ignored and range cases.
	task automatic test_directed();
		send_item(bkcp_pkg::K_TICK, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF);
		send_item(bkcp_pkg::K_START);
		send_item(bkcp_pkg::K_TICK, 0, 0, 0, 0, 0, 0, 32'h10000);
		send_item(bkcp_pkg::K_APPEND, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
		send_item(bkcp_pkg::K_APPEND, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
			32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
		set_registers(1'b0, 16'd0, 16'hFFFF, 8'd255, 16'd1);
		send_item(bkcp_pkg::K_TICK, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF);
		send_item(bkcp_pkg::K_SET, 0, 0, 0, 0, 0, 0, 0, 32'sh80000000);
		send_item(bkcp_pkg::K_SET, 0, 0, 0, 0, 0, 0, 0, 32'sh7FFFFFFF);
		send_item(bkcp_pkg::K_SET, 0, 0, 0, 0, 0, 0, 0, 32'sh00100000);
		send_item(bkcp_pkg::K_START);
		send_item(bkcp_pkg::K_TICK, 0, 0, 0, 0, 0, 0, 32'h00000001);
		send_item(bkcp_pkg::K_TICK, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF);
		send_item(3'd6);
		send_item(3'd7);
		send_item(bkcp_pkg::K_STOP);
		send_item(bkcp_pkg::K_CLEAR);
		for (int i = 0; i < NKEYS + 1; i++) append_near(i * 4);
		send_item(bkcp_pkg::K_SET, 0, 0, 0, 0, 0, 0, 0, 32'sh00A00000);
		send_item(bkcp_pkg::K_CLEAR);
	endtask

	// Sweeps register settings while playing random well-formed curves.
	task automatic test_random_playback();
		int nk, kind_pick, ef;
		for (int phase = 0; phase < 12; phase++) begin
			// Phase 3 runs without the random idle gaps before items.
			calm_sender = (phase == 3);
			ef = (phase == 0) ? 0 : $urandom_range(8, 300);
			set_registers(1'($urandom_range(1)), 16'($urandom_range(ef / 2)),
				(phase == 11) ? 16'hFFFF : ef[15:0],
				(phase == 1) ? 8'd1 : 8'($urandom_range(1, 255)),
				(phase == 2) ? 16'hFFFF : 16'($urandom_range(1, 4000)));
			send_item(bkcp_pkg::K_CLEAR);
			nk = $urandom_range(2, 10);
			for (int i = 0; i < nk; i++) append_near(i * (ef + 4) / (nk - 1));
			send_item(bkcp_pkg::K_START);
			for (int i = 0; i < 90; i++) begin
				kind_pick = $urandom_range(99);
				if (kind_pick < 60)
					send_item(bkcp_pkg::K_TICK, 0, 0, 0, 0, 0, 0, $urandom_range(0, 40000));
				else if (kind_pick < 75)
					send_item(bkcp_pkg::K_SET, 0, 0, 0, 0, 0, 0, 0,
						$urandom_range(0, (ef + 2) * 65536));
				else if (kind_pick < 80) send_item(bkcp_pkg::K_START);
				else if (kind_pick < 83) send_item(bkcp_pkg::K_STOP);
				else if (kind_pick < 86) append_near($urandom_range(ef));
				else if (kind_pick < 88) send_item(bkcp_pkg::K_CLEAR);
				else
					send_item(3'($urandom_range(7)), $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom, $urandom);
			end
			calm_sender = 0;
		end
	endtask

	// Result checker: every done pulse is compared with the oldest prediction.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (curve_value !== exp_r.curve) begin
					$error("curve_value expected %0d got %0d", exp_r.curve, curve_value);
					errors++;
				end
				if (frame_now !== exp_r.frame) begin
					$error("frame_now expected %0d got %0d", exp_r.frame, frame_now);
					errors++;
				end
				if (key_now !== exp_r.key) begin
					$error("key_now expected %0d got %0d", exp_r.key, key_now);
					errors++;
				end
				if (playing !== exp_r.play) begin
					$error("playing expected %0d got %0d", exp_r.play, playing);
					errors++;
				end
				if (status !== exp_r.stat) begin
					$error("status expected %0d got %0d", exp_r.stat, status);
					errors++;
				end
			end
		end
	end

	// Watchdog: too long without any item or result moving ends the run.
	always @(posedge clk) begin
		if ((start && !busy) || done || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_bezier_keyframe_curve_player_top failed");
			$finish;
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		start = 0;
		kind = 0;
		{center_x, center_y, left_x, left_y, right_x, right_y} = '0;
		elapsed = 0;
		frame_value = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		errors = 0;
		idle_cycles = 0;
		calm_sender = 0;
		n_keys = 0;
		cur_frame = 0;
		cur_key = 0;
		is_running = 0;
		held_value = 0;
		reg_loop = 0;
		reg_start = 0;
		reg_end = 0;
		reg_fps = bkcp_pkg::FPS_RST;
		reg_tol = bkcp_pkg::TOL_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random_playback();
		drain();
		repeat (400) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("tb_bezier_keyframe_curve_player_top passed");
		else
			$display("tb_bezier_keyframe_curve_player_top failed");
		$finish;
	end

endmodule
